/* rtl/core/srf_pkg.sv */
// ----------------------------------------------------------------------------
// srf_pkg
// Shared types, register codes and tables of the grid sync PLL.
// ----------------------------------------------------------------------------
package srf_pkg;

  localparam int unsigned ITER_W       = 5;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned SQRT_STEPS   = 18;
  localparam int unsigned DIV_STEPS    = 17;

  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_RATE  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_FLOOR   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_CEILING = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_FLOOR    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_CEILING  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_BAND     = 4'd7;

  localparam logic [30:0]        RST_NOMINAL_RATE  = 31'd10737418;
  localparam logic signed [31:0] RST_INTEG_FLOOR   = -32'sd1073742;
  localparam logic signed [31:0] RST_INTEG_CEILING = 32'sd1073742;
  localparam logic signed [31:0] RST_RATE_FLOOR    = 32'sd9663676;
  localparam logic signed [31:0] RST_RATE_CEILING  = 32'sd11811160;
  localparam logic [14:0]        RST_LOCK_BAND     = 15'd1638;

  typedef enum logic [3:0] {
    S_IDLE, S_CLARKE, S_ROT, S_CORDIC, S_SCALE, S_SQUARE, S_SQRT,
    S_DINIT, S_DIV, S_ERR, S_MUL, S_INTEG, S_RATE
  } srf_state_t;

  typedef struct packed {
    logic [30:0]        prop_gain;
    logic [30:0]        integ_gain;
    logic [30:0]        nominal_rate;
    logic signed [31:0] integ_floor;
    logic signed [31:0] integ_ceiling;
    logic signed [31:0] rate_floor;
    logic signed [31:0] rate_ceiling;
    logic [14:0]        lock_band;
  } srf_cfg_t;

  typedef struct packed {
    logic              load;
    logic              clarke;
    logic              rot;
    logic              cordic;
    logic              scale;
    logic              square;
    logic              sqrt_step;
    logic              div_init;
    logic              div_step;
    logic              err;
    logic              mul;
    logic              integ;
    logic              commit;
    logic [ITER_W-1:0] iter;
  } srf_cmd_t;

  typedef struct packed {
    logic out_free;
  } srf_stat_t;

  // arctangent of 2^-i in 2^-32 turn units
  function automatic logic signed [31:0] atan_lookup(input logic [3:0] i);
    logic signed [31:0] v;
    unique case (i)
      4'd0:  v = 32'sd536870912;
      4'd1:  v = 32'sd316933406;
      4'd2:  v = 32'sd167458907;
      4'd3:  v = 32'sd85004756;
      4'd4:  v = 32'sd42667331;
      4'd5:  v = 32'sd21354465;
      4'd6:  v = 32'sd10679838;
      4'd7:  v = 32'sd5340245;
      4'd8:  v = 32'sd2670163;
      4'd9:  v = 32'sd1335087;
      4'd10: v = 32'sd667544;
      4'd11: v = 32'sd333772;
      4'd12: v = 32'sd166886;
      4'd13: v = 32'sd83443;
      4'd14: v = 32'sd41722;
      4'd15: v = 32'sd20861;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/srf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// srf_cfg_regs
// Loop filter and lock detector configuration registers.
// ----------------------------------------------------------------------------
module srf_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output srf_pkg::srf_cfg_t             cfg
);
  import srf_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain     <= '0;
      cfg.integ_gain    <= '0;
      cfg.nominal_rate  <= RST_NOMINAL_RATE;
      cfg.integ_floor   <= RST_INTEG_FLOOR;
      cfg.integ_ceiling <= RST_INTEG_CEILING;
      cfg.rate_floor    <= RST_RATE_FLOOR;
      cfg.rate_ceiling  <= RST_RATE_CEILING;
      cfg.lock_band     <= RST_LOCK_BAND;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROP_GAIN:     cfg.prop_gain     <= cfg_data[30:0];
        REG_INTEG_GAIN:    cfg.integ_gain    <= cfg_data[30:0];
        REG_NOMINAL_RATE:  cfg.nominal_rate  <= cfg_data[30:0];
        REG_INTEG_FLOOR:   cfg.integ_floor   <= $signed(cfg_data);
        REG_INTEG_CEILING: cfg.integ_ceiling <= $signed(cfg_data);
        REG_RATE_FLOOR:    cfg.rate_floor    <= $signed(cfg_data);
        REG_RATE_CEILING:  cfg.rate_ceiling  <= $signed(cfg_data);
        REG_LOCK_BAND:     cfg.lock_band     <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/core/srf_ctrl.sv */
// ----------------------------------------------------------------------------
// srf_ctrl
// Sequencer for the PLL datapath: one sample at a time through each unit.
// ----------------------------------------------------------------------------
module srf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  srf_pkg::srf_stat_t stat,
  output srf_pkg::srf_cmd_t  cmd
);
  import srf_pkg::*;

  srf_state_t        state, state_next;
  logic [ITER_W-1:0] iter, iter_next;
  logic              cordic_last, sqrt_last, div_last;

  assign cordic_last = (iter == ITER_W'(CORDIC_STEPS - 1));
  assign sqrt_last   = (iter == ITER_W'(SQRT_STEPS - 1));
  assign div_last    = (iter == ITER_W'(DIV_STEPS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_CLARKE;
      S_CLARKE: state_next = S_ROT;
      S_ROT:    state_next = S_CORDIC;
      S_CORDIC: if (cordic_last) state_next = S_SCALE;
      S_SCALE:  state_next = S_SQUARE;
      S_SQUARE: state_next = S_SQRT;
      S_SQRT:   if (sqrt_last) state_next = S_DINIT;
      S_DINIT:  state_next = S_DIV;
      S_DIV:    if (div_last) state_next = S_ERR;
      S_ERR:    state_next = S_MUL;
      S_MUL:    state_next = S_INTEG;
      S_INTEG:  state_next = S_RATE;
      S_RATE:   if (stat.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    iter_next = '0;
    if ((state == S_CORDIC && !cordic_last) || (state == S_SQRT && !sqrt_last) ||
        (state == S_DIV && !div_last)) begin
      iter_next = iter + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.iter      = iter;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.clarke    = (state == S_CLARKE);
    cmd.rot       = (state == S_ROT);
    cmd.cordic    = (state == S_CORDIC);
    cmd.scale     = (state == S_SCALE);
    cmd.square    = (state == S_SQUARE);
    cmd.sqrt_step = (state == S_SQRT);
    cmd.div_init  = (state == S_DINIT);
    cmd.div_step  = (state == S_DIV);
    cmd.err       = (state == S_ERR);
    cmd.mul       = (state == S_MUL);
    cmd.integ     = (state == S_INTEG);
    cmd.commit    = (state == S_RATE) && stat.out_free;
    in_ready      = (state == S_IDLE);
  end

`ifndef SYNTHESIS
  a_iter_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_CORDIC && state != S_SQRT && state != S_DIV) |-> iter == '0)
    else $error("iteration count left over outside a loop state");
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.cordic, cmd.sqrt_step, cmd.div_step, cmd.commit}))
    else $error("more than one datapath step issued");
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> stat.out_free)
    else $error("commit while output slot busy");
`endif

endmodule

/* rtl/core/srf_datapath.sv */
// ----------------------------------------------------------------------------
// srf_datapath
// Clarke/Park transform, CORDIC, square root, divider, PI filter and
// phase accumulator with the output register.
// ----------------------------------------------------------------------------
module srf_datapath #(
  parameter int unsigned LOCK_DWELL = 1024,
  parameter int unsigned MAG_EPS    = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  srf_pkg::srf_cmd_t   cmd,
  output srf_pkg::srf_stat_t  stat,
  input  srf_pkg::srf_cfg_t   cfg,
  input  logic signed [15:0]  phase_a,
  input  logic signed [15:0]  phase_b,
  input  logic signed [15:0]  phase_c,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         angle,
  output logic signed [31:0]  rate,
  output logic                locked
);
  import srf_pkg::*;

  // sample and transform registers
  logic signed [15:0] sa, sb, sc;
  logic signed [16:0] ax, by;
  logic signed [19:0] cx, cy;
  logic signed [31:0] cz;
  logic signed [17:0] d, q;
  logic [17:0]        aq;
  logic [35:0]        sq_n, sq_r, sq_bit;
  logic [18:0]        rem;
  logic [16:0]        nsh, quo;
  logic signed [15:0] err;
  logic signed [31:0] inc, prop;
  // loop state
  logic [31:0]        phase_acc;
  logic signed [31:0] integ;
  logic [15:0]        dwell;

  // clarke
  logic signed [18:0] s_alpha;
  logic signed [17:0] s_beta;
  logic signed [35:0] p_alpha, p_beta;
  assign s_alpha = 19'(sa) + 19'(sa) - 19'(sb) - 19'(sc);
  assign s_beta  = 18'(sb) - 18'(sc);
  assign p_alpha = 36'(s_alpha) * 36'sd21845;
  assign p_beta  = 36'(s_beta) * 36'sd37837;

  // quadrant pre-rotation
  logic signed [19:0] ex, ey, rx, ry;
  assign ex = 20'(ax);
  assign ey = 20'(by);
  always_comb begin
    unique case (phase_acc[31:30])
      2'd0:    begin rx = ex;  ry = ey;  end
      2'd1:    begin rx = ey;  ry = -ex; end
      2'd2:    begin rx = -ex; ry = -ey; end
      default: begin rx = -ey; ry = ex;  end
    endcase
  end

  // cordic step
  logic signed [19:0] xs, ys;
  logic signed [31:0] at;
  assign xs = cx >>> cmd.iter[3:0];
  assign ys = cy >>> cmd.iter[3:0];
  assign at = atan_lookup(cmd.iter[3:0]);

  // gain correction
  logic signed [36:0] p_d, p_q;
  assign p_d = 37'(cx) * 37'sd39797;
  assign p_q = 37'(cy) * 37'sd39797;

  // magnitude squared
  logic signed [35:0] dx, qx, dd, qq;
  assign dx = 36'(d);
  assign qx = 36'(q);
  assign dd = dx * dx;
  assign qq = qx * qx;

  // square root step
  logic [35:0] sq_t;
  assign sq_t = sq_r + sq_bit;

  // divide step
  logic [17:0] mag;
  logic [19:0] dv_t, dv_m;
  assign mag  = sq_r[17:0];
  assign dv_t = {rem, nsh[16]};
  assign dv_m = {2'b0, mag};

  // error saturate
  logic signed [15:0] err_calc;
  always_comb begin
    err_calc = '0;
    if (mag > 18'(MAG_EPS)) begin
      if (q < 0) begin
        err_calc = (quo > 17'd32768) ? -16'sd32768 : 16'(-$signed({1'b0, quo}));
      end else begin
        err_calc = (quo > 17'd32767) ? 16'sd32767 : $signed(quo[15:0]);
      end
    end
  end

  // pi products
  logic signed [47:0] p_int, p_prop;
  assign p_int  = 48'($signed({1'b0, cfg.integ_gain})) * 48'(err);
  assign p_prop = 48'($signed({1'b0, cfg.prop_gain})) * 48'(err);

  // integrator clamp, floor first then ceiling
  logic signed [32:0] i_sum, i_lo;
  logic signed [31:0] i_new;
  assign i_sum = 33'(integ) + 33'(inc);
  assign i_lo  = (i_sum < 33'(cfg.integ_floor)) ? 33'(cfg.integ_floor) : i_sum;
  assign i_new = (i_lo > 33'(cfg.integ_ceiling)) ? cfg.integ_ceiling : i_lo[31:0];

  logic signed [33:0] r_sum, r_lo;
  logic signed [31:0] r_new;
  assign r_sum = $signed({3'b0, cfg.nominal_rate}) + 34'(prop) + 34'(integ);
  assign r_lo  = (r_sum < 34'(cfg.rate_floor)) ? 34'(cfg.rate_floor) : r_sum;
  assign r_new = (r_lo > 34'(cfg.rate_ceiling)) ? cfg.rate_ceiling : r_lo[31:0];

  // lock detector
  logic [16:0] abs_err;
  logic [15:0] dwell_next;
  assign abs_err = (err < 0) ? 17'(-17'(err)) : 17'(err);
  always_comb begin
    dwell_next = '0;
    if (abs_err < {2'b0, cfg.lock_band}) begin
      dwell_next = (dwell < 16'(LOCK_DWELL)) ? dwell + 1'b1 : dwell;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

  // payload path
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sa <= phase_a;
      sb <= phase_b;
      sc <= phase_c;
    end
    if (cmd.clarke) begin
      ax <= p_alpha[32:16];
      by <= p_beta[32:16];
    end
    if (cmd.rot) begin
      cx <= rx;
      cy <= ry;
      cz <= -$signed({2'b0, phase_acc[29:0]});
    end
    if (cmd.cordic) begin
      if (cz[31]) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + at;
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - at;
      end
    end
    if (cmd.scale) begin
      d <= p_d[33:16];
      q <= p_q[33:16];
    end
    if (cmd.square) begin
      sq_n   <= 36'(dd + qq);
      sq_r   <= '0;
      sq_bit <= 36'd1 << 34;
      aq     <= (q < 0) ? 18'(-q) : 18'(q);
    end
    if (cmd.sqrt_step) begin
      if (sq_n >= sq_t) begin
        sq_n <= sq_n - sq_t;
        sq_r <= (sq_r >> 1) + sq_bit;
      end else begin
        sq_r <= sq_r >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
    if (cmd.div_init) begin
      rem <= 19'(aq >> 2);
      nsh <= {aq[1:0], 15'b0};
      quo <= '0;
    end
    if (cmd.div_step) begin
      if (dv_t >= dv_m) begin
        rem <= 19'(dv_t - dv_m);
        quo <= {quo[15:0], 1'b1};
      end else begin
        rem <= dv_t[18:0];
        quo <= {quo[15:0], 1'b0};
      end
      nsh <= {nsh[15:0], 1'b0};
    end
    if (cmd.err) begin
      err <= err_calc;
    end
    if (cmd.mul) begin
      inc  <= p_int[46:15];
      prop <= p_prop[46:15];
    end
  end

  // loop state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
      integ     <= '0;
      dwell     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.integ) begin
        integ <= i_new;
      end
      if (cmd.commit) begin
        phase_acc <= phase_acc + r_new;
        dwell     <= dwell_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      angle  <= phase_acc + r_new;
      rate   <= r_new;
      locked <= (dwell_next >= 16'(LOCK_DWELL));
    end
  end

`ifndef SYNTHESIS
  a_dwell_cap: assert property (@(posedge clk) disable iff (rst)
    dwell <= 16'(LOCK_DWELL))
    else $error("dwell count past its limit");
  a_integ_band: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.integ) && $past(cfg.integ_floor <= cfg.integ_ceiling) |->
      (integ >= $past(cfg.integ_floor)) && (integ <= $past(cfg.integ_ceiling)))
    else $error("integrator outside its clamp band");
  a_acc_step: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.commit) |-> phase_acc == angle)
    else $error("phase accumulator and angle output disagree");
`endif

endmodule

/* rtl/core/srf_pll_grid_sync.sv */
// ----------------------------------------------------------------------------
// srf_pll_grid_sync
// Three-phase synchronous-frame PLL: grid samples in, angle, rate, lock out.
// ----------------------------------------------------------------------------
// the result is registered in the rate state, which waits while the output is
//   busy; a new sample is accepted only after the previous result is committed,
//   since the 16-step cordic, the 18-step square root and the 17-step divider
//   run one after another
// reset: synchronous; clears the phase accumulator, integrator, dwell count
//   and output valid, and loads the register defaults
module srf_pll_grid_sync #(
  parameter int unsigned LOCK_DWELL = 1024,
  parameter int unsigned MAG_EPS    = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [47:0]                   s_tdata,   // phase_a, phase_b, phase_c
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [71:0]                   m_tdata,   // angle, rate, locked, zero pad
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [srf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import srf_pkg::*;

  srf_cfg_t           cfg;
  srf_cmd_t           cmd;
  srf_stat_t          stat;
  logic [31:0]        angle;
  logic signed [31:0] rate;
  logic               locked;

  srf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  srf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  srf_datapath #(
    .LOCK_DWELL (LOCK_DWELL),
    .MAG_EPS    (MAG_EPS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg),
    .phase_a   ($signed(s_tdata[15:0])),
    .phase_b   ($signed(s_tdata[31:16])),
    .phase_c   ($signed(s_tdata[47:32])),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .angle     (angle),
    .rate      (rate),
    .locked    (locked)
  );

  assign m_tdata = {7'b0, locked, rate, angle};

endmodule
